[sv/can_signal_extract_scale_macros.svh]
// Assertion macros shared by the CAN signal decoder RTL.
`ifndef CAN_SIGNAL_EXTRACT_SCALE_MACROS_SVH
`define CAN_SIGNAL_EXTRACT_SCALE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSE_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CSE_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cse_pkg.sv]
// Types and constants shared by the CAN signal decoder modules.
`timescale 1ns / 1ps

package cse_pkg;

    localparam int         BITS_PER_BYTE  = 8;
    localparam logic [2:0] SIG_BIT_MASK   = 3'd7;
    localparam logic [6:0] MAX_BIT_LENGTH = 7'd64;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_LENGTH = 2'd1;
    localparam logic [1:0] ST_KIND   = 2'd2;

    // Value kind codes.
    localparam logic [1:0] KIND_INT     = 2'd0;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic signed [63:0] PHYS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] PHYS_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0]        payload;
        logic [3:0]         byte_count;
        logic [5:0]         start_bit;
        logic [6:0]         bit_length;
        logic               motorola_order;
        logic               is_signed;
        logic [1:0]         value_kind;
        logic signed [31:0] scale_factor;
        logic signed [63:0] offset_value;
    } t_item;

    // After the length check and the barrel shift.
    typedef struct packed {
        logic [1:0]         status;
        logic               is_signed;
        logic [1:0]         value_kind;
        logic [6:0]         bit_length;
        logic [63:0]        field;
        logic signed [31:0] scale_factor;
        logic signed [63:0] offset_value;
    } t_s1;

    // Final raw value and the operand magnitudes.
    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         value_kind;
        logic [63:0]        raw_bits;
        logic               prod_neg;
        logic [63:0]        raw_mag;
        logic [31:0]        scale_mag;
        logic signed [63:0] offset_value;
    } t_s2;

    // Two 32 by 32 partial products.
    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         value_kind;
        logic [63:0]        raw_bits;
        logic               prod_neg;
        logic [63:0]        part_lo;
        logic [63:0]        part_hi;
        logic signed [63:0] offset_value;
    } t_s3;

    // Rescaled product magnitude.
    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         value_kind;
        logic [63:0]        raw_bits;
        logic               prod_neg;
        logic               huge;
        logic [63:0]        mag;
        logic signed [63:0] offset_value;
    } t_s4;

    typedef struct packed {
        logic [1:0]         status;
        logic [63:0]        raw_bits;
        logic signed [63:0] physical_value;
        logic               saturated;
    } t_result;

endpackage

[sv/cse_in_if.sv]
// Valid/ready channel that carries one payload and signal descriptor per item.
`timescale 1ns / 1ps

interface cse_in_if;
    logic               valid;
    logic               ready;
    logic [63:0]        payload;
    logic [3:0]         byte_count;
    logic [5:0]         start_bit;
    logic [6:0]         bit_length;
    logic               motorola_order;
    logic               is_signed;
    logic [1:0]         value_kind;
    logic signed [31:0] scale_factor;
    logic signed [63:0] offset_value;

    modport source (
        output valid, payload, byte_count, start_bit, bit_length, motorola_order,
        output is_signed, value_kind, scale_factor, offset_value,
        input  ready
    );

    modport sink (
        input  valid, payload, byte_count, start_bit, bit_length, motorola_order,
        input  is_signed, value_kind, scale_factor, offset_value,
        output ready
    );
endinterface

[sv/cse_out_if.sv]
// Valid/ready channel that carries one decoded signal per item.
`timescale 1ns / 1ps

interface cse_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [63:0]        raw_bits;
    logic signed [63:0] physical_value;
    logic               saturated;

    modport source (
        output valid, status, raw_bits, physical_value, saturated,
        input  ready
    );

    modport sink (
        input  valid, status, raw_bits, physical_value, saturated,
        output ready
    );
endinterface

[sv/cse_extract.sv]
// Length check, bit gathering and sign extension (two pipeline stages).
`timescale 1ns / 1ps

module cse_extract #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cse_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output cse_pkg::t_s2  o_stage
);
    import cse_pkg::*;

    localparam logic [6:0] LIMIT_MAX = 7'(PAYLOAD_BYTES);

    logic [2:0]   w_bit_ofs;
    logic [6:0]   w_limit;
    logic [7:0]   w_end_byte;
    logic [63:0]  w_swapped;
    logic [5:0]   w_lin_start;
    logic [7:0]   w_mot_shift;
    logic [127:0] w_mot_ext;
    logic [63:0]  w_mask;
    logic [63:0]  w_top;
    logic [63:0]  w_field;
    logic [63:0]  w_raw;
    logic         w_ext;
    logic         w_rneg;
    logic [31:0]  w_sc;
    logic         w_rdy1;
    logic         w_rdy2;
    logic         r_v1;
    logic         r_v2;
    t_s1          n_s1;
    t_s1          r_s1;
    t_s2          n_s2;
    t_s2          r_s2;

    // Stage 1: where the signal ends, and the bits moved to the bottom of a word.
    always_comb begin
        w_bit_ofs = i_item.start_bit[2:0] & SIG_BIT_MASK;
        w_limit = ({3'b0, i_item.byte_count} < LIMIT_MAX) ? {3'b0, i_item.byte_count}
                                                          : LIMIT_MAX;
        if (i_item.motorola_order) begin
            w_end_byte = 8'(({2'b0, i_item.start_bit} / BITS_PER_BYTE)
                + ((8'(i_item.bit_length) + 8'd6 - 8'(w_bit_ofs)) / BITS_PER_BYTE));
        end else begin
            w_end_byte = 8'(({2'b0, i_item.start_bit} + {1'b0, i_item.bit_length} - 8'd1)
                / BITS_PER_BYTE);
        end

        // Motorola bits form one running sequence in the byte-reversed word.
        for (int b = 0; b < 8; b++) begin
            w_swapped[8*b +: 8] = i_item.payload[8*(7-b) +: 8];
        end
        w_lin_start = i_item.start_bit ^ {3'b0, SIG_BIT_MASK};
        w_mot_shift = 8'd128 - {2'b0, w_lin_start} - {1'b0, i_item.bit_length};
        w_mot_ext   = {w_swapped, 64'b0};

        n_s1.is_signed    = i_item.is_signed;
        n_s1.value_kind   = i_item.value_kind;
        n_s1.bit_length   = i_item.bit_length;
        n_s1.scale_factor = i_item.scale_factor;
        n_s1.offset_value = i_item.offset_value;
        n_s1.field = i_item.motorola_order ? 64'(w_mot_ext >> w_mot_shift)
                                           : (i_item.payload >> i_item.start_bit);

        if (i_item.bit_length > MAX_BIT_LENGTH) begin
            n_s1.status = ST_LENGTH;
        end else if ((i_item.bit_length != 7'd0) && (w_end_byte >= {1'b0, w_limit})) begin
            n_s1.status = ST_LENGTH;
        end else if (i_item.value_kind == KIND_UNKNOWN) begin
            n_s1.status = ST_KIND;
        end else begin
            n_s1.status = ST_OK;
        end
    end

    // Stage 2: trim to the signal length, sign-extend, split into magnitudes.
    always_comb begin
        w_mask  = ~({64{1'b1}} << r_s1.bit_length);
        w_top   = w_mask & ~(w_mask >> 1);
        w_field = r_s1.field & w_mask;
        w_ext   = (r_s1.value_kind == KIND_INT) && r_s1.is_signed && (|(w_field & w_top));
        w_raw   = w_ext ? (w_field | ~w_mask) : w_field;
        if (r_s1.status != ST_OK) begin
            w_raw = '0;
        end
        w_rneg = (r_s1.value_kind == KIND_INT) && r_s1.is_signed && w_raw[63];
        w_sc   = r_s1.scale_factor;

        n_s2.status       = r_s1.status;
        n_s2.value_kind   = r_s1.value_kind;
        n_s2.raw_bits     = w_raw;
        n_s2.raw_mag      = w_rneg ? (~w_raw + 64'd1) : w_raw;
        n_s2.scale_mag    = w_sc[31] ? (~w_sc + 32'd1) : w_sc;
        n_s2.prod_neg     = w_rneg ^ w_sc[31];
        n_s2.offset_value = r_s1.offset_value;
    end

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_stage = r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end
endmodule

[sv/cse_scale.sv]
// Raw times scale product and fixed-point rescale (two pipeline stages).
`timescale 1ns / 1ps

module cse_scale #(
    parameter int SCALE_FRAC_BITS = 16,
    parameter int OUT_FRAC_BITS   = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  cse_pkg::t_s2 i_stage,
    output logic         o_valid,
    input  logic         i_ready,
    output cse_pkg::t_s4 o_stage
);
    import cse_pkg::*;

    localparam int SHIFT_DIFF  = OUT_FRAC_BITS - SCALE_FRAC_BITS;
    localparam int SHIFT_LEFT  = (SHIFT_DIFF > 0) ? SHIFT_DIFF : 0;
    localparam int SHIFT_RIGHT = (SHIFT_DIFF < 0) ? -SHIFT_DIFF : 0;
    localparam int HALF_POS    = (SHIFT_RIGHT > 0) ? SHIFT_RIGHT - 1 : 0;
    localparam int WIDE_W      = 96 + SHIFT_LEFT;
    // Half an output LSB, so that the right shift rounds ties away from zero.
    localparam logic [WIDE_W-1:0] ROUND_ADD =
        (SHIFT_RIGHT > 0) ? (WIDE_W'(1) << HALF_POS) : '0;

    logic [WIDE_W-1:0] w_sum;
    logic [WIDE_W-1:0] w_scaled;
    logic              w_rdy3;
    logic              w_rdy4;
    logic              r_v3;
    logic              r_v4;
    t_s3               n_s3;
    t_s3               r_s3;
    t_s4               n_s4;
    t_s4               r_s4;

    // Stage 3: two 32 by 32 multiplies on the magnitudes.
    always_comb begin
        n_s3.status       = i_stage.status;
        n_s3.value_kind   = i_stage.value_kind;
        n_s3.raw_bits     = i_stage.raw_bits;
        n_s3.prod_neg     = i_stage.prod_neg;
        n_s3.offset_value = i_stage.offset_value;
        n_s3.part_lo      = i_stage.raw_mag[31:0] * i_stage.scale_mag;
        n_s3.part_hi      = i_stage.raw_mag[63:32] * i_stage.scale_mag;
    end

    // Stage 4: join the partial products, move the binary point, flag overflow.
    always_comb begin
        w_sum    = WIDE_W'(r_s3.part_lo) + (WIDE_W'(r_s3.part_hi) << 32) + ROUND_ADD;
        w_scaled = (w_sum >> SHIFT_RIGHT) << SHIFT_LEFT;

        n_s4.status       = r_s3.status;
        n_s4.value_kind   = r_s3.value_kind;
        n_s4.raw_bits     = r_s3.raw_bits;
        n_s4.prod_neg     = r_s3.prod_neg;
        n_s4.offset_value = r_s3.offset_value;
        n_s4.huge         = |w_scaled[WIDE_W-1:64];
        n_s4.mag          = w_scaled[63:0];
    end

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign o_ready = w_rdy3;
    assign o_valid = r_v4;
    assign o_stage = r_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy3) begin
                r_v3 <= i_valid;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && i_valid) begin
            r_s3 <= n_s3;
        end
        if (w_rdy4 && r_v3) begin
            r_s4 <= n_s4;
        end
    end
endmodule

[sv/cse_sat.sv]
// Offset addition, saturation and the output register.
`timescale 1ns / 1ps

module cse_sat (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  cse_pkg::t_s4     i_stage,
    output logic             o_valid,
    input  logic             i_ready,
    output cse_pkg::t_result o_result
);
    import cse_pkg::*;

    localparam logic signed [65:0] SUM_MAX = $signed({2'b00, PHYS_MAX});
    localparam logic signed [65:0] SUM_MIN = $signed({2'b11, PHYS_MIN});

    logic signed [65:0] w_term;
    logic signed [65:0] w_sum;
    logic               w_rdy;
    logic               r_v;
    t_result            n_res;
    t_result            r_res;

    always_comb begin
        w_term = i_stage.prod_neg ? -$signed({2'b00, i_stage.mag})
                                  : $signed({2'b00, i_stage.mag});
        w_sum  = w_term + $signed({{2{i_stage.offset_value[63]}}, i_stage.offset_value});

        n_res.status   = i_stage.status;
        n_res.raw_bits = i_stage.raw_bits;
        if ((i_stage.status != ST_OK) || (i_stage.value_kind != KIND_INT)) begin
            n_res.physical_value = '0;
            n_res.saturated      = 1'b0;
        end else if (i_stage.huge) begin
            n_res.physical_value = i_stage.prod_neg ? PHYS_MIN : PHYS_MAX;
            n_res.saturated      = 1'b1;
        end else if (w_sum > SUM_MAX) begin
            n_res.physical_value = PHYS_MAX;
            n_res.saturated      = 1'b1;
        end else if (w_sum < SUM_MIN) begin
            n_res.physical_value = PHYS_MIN;
            n_res.saturated      = 1'b1;
        end else begin
            n_res.physical_value = w_sum[63:0];
            n_res.saturated      = 1'b0;
        end
    end

    assign w_rdy    = !r_v || i_ready;
    assign o_ready  = w_rdy;
    assign o_valid  = r_v;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) begin
            r_res <= n_res;
        end
    end
endmodule

[sv/can_signal_extract_scale.sv]
// Top level of the CAN signal decoder: extraction, scaling and saturation pipeline.
`timescale 1ns / 1ps
`include "can_signal_extract_scale_macros.svh"

// Decodes one signal from one CAN payload per item. Each input item carries
// up to eight payload bytes, the number of valid bytes and a signal
// descriptor; each input item gives exactly one result item, in order.
// Bits are gathered in Intel (start_bit is the LSB) or Motorola (start_bit is
// the MSB, walking down a byte and on into bit 7 of the next byte) order.
// A signal that ends at or past the valid bytes, or is longer than 64 bits,
// reports status 1 with all other fields zero; an unknown value kind reports
// status 2, also with zero fields, and a length fault takes precedence.
// Integer signals are sign-extended when marked signed, then multiplied by
// the Q16.16 scale factor (SCALE_FRAC_BITS fraction bits), brought to the
// output format (OUT_FRAC_BITS fraction bits, rounding half away from zero
// when bits are dropped), added to the offset and clipped to 64 signed bits,
// with saturated set when clipping happened. Float and double signals return
// their raw bits unchanged with a physical value of zero.
// Throughput is one item per clock cycle while the output is not stalled.
// An item passes through five register stages: length check and barrel
// shift, sign extension, two 32 by 32 multiplies, product join and rescale,
// then offset add and saturation into the output register. Each stage
// carries its own valid bit and a stage accepts whenever it is empty or its
// successor accepts, so a stalled output holds its result, fills the
// pipeline from the back and only then drops input ready. The block holds
// no other state.
module can_signal_extract_scale #(
    parameter int PAYLOAD_BYTES   = 8,
    parameter int SCALE_FRAC_BITS = 16,
    parameter int OUT_FRAC_BITS   = 32
) (
    input logic       i_clk,
    input logic       i_rst_n,
    cse_in_if.sink    i_item,
    cse_out_if.source o_result
);
    import cse_pkg::*;

    t_item   w_item;
    t_s2     w_s2;
    t_s4     w_s4;
    t_result w_res;
    logic    w_in_ready;
    logic    w_s2_valid;
    logic    w_s2_ready;
    logic    w_s4_valid;
    logic    w_s4_ready;
    logic    w_out_valid;

    // Gather the channel's fields into one word for the pipeline.
    always_comb begin
        w_item.payload        = i_item.payload;
        w_item.byte_count     = i_item.byte_count;
        w_item.start_bit      = i_item.start_bit;
        w_item.bit_length     = i_item.bit_length;
        w_item.motorola_order = i_item.motorola_order;
        w_item.is_signed      = i_item.is_signed;
        w_item.value_kind     = i_item.value_kind;
        w_item.scale_factor   = i_item.scale_factor;
        w_item.offset_value   = i_item.offset_value;
    end

    assign i_item.ready = w_in_ready;

    // Stages one and two: status, bit gathering, sign extension.
    cse_extract #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_extract (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (w_in_ready),
        .i_item  (w_item),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_stage (w_s2)
    );

    // Stages three and four: exact product and change of fixed-point format.
    cse_scale #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
        .OUT_FRAC_BITS   (OUT_FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_stage (w_s2),
        .o_valid (w_s4_valid),
        .i_ready (w_s4_ready),
        .o_stage (w_s4)
    );

    // Stage five: offset, saturation, output register.
    cse_sat u_sat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_s4_valid),
        .o_ready  (w_s4_ready),
        .i_stage  (w_s4),
        .o_valid  (w_out_valid),
        .i_ready  (o_result.ready),
        .o_result (w_res)
    );

    assign o_result.valid          = w_out_valid;
    assign o_result.status         = w_res.status;
    assign o_result.raw_bits       = w_res.raw_bits;
    assign o_result.physical_value = w_res.physical_value;
    assign o_result.saturated      = w_res.saturated;

    // A faulted item must not leak any decoded data.
    `CSE_CHECK(a_fault_zero, o_result.valid && (o_result.status != ST_OK), (o_result.raw_bits == 64'd0) && (o_result.physical_value == 64'sd0) && !o_result.saturated, "faulted result carries data")
    // Clipping only ever lands on one of the two range limits.
    `CSE_CHECK(a_sat_limit, o_result.valid && o_result.saturated, (o_result.physical_value == PHYS_MAX) || (o_result.physical_value == PHYS_MIN), "saturated value is not a range limit")
    // An item handed to the last stage is presented on the next cycle.
    `CSE_CHECK_NEXT(a_out_load, w_s4_valid && w_s4_ready, o_result.valid, "item lost entering the output register")
    // A stalled result must hold back the stage in front of it.
    `CSE_CHECK(a_stall_back, o_result.valid && !o_result.ready, !w_s4_ready, "output stall not propagated")
endmodule

[tb/sv/tb_can_signal_extract_scale.sv]
// Testbench for the CAN signal decoder: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module tb_can_signal_extract_scale;
    import cse_pkg::*;

    // The instance keeps its default parameters, so the predictor uses the same values.
    localparam int CAN_BYTES      = 8;
    localparam int SCALE_FRAC     = 16;
    localparam int OUT_FRAC       = 32;
    localparam int PROD_SHIFT     = OUT_FRAC - SCALE_FRAC;
    localparam int PIPE_LATENCY   = 5;
    localparam int SETTLE_CYCLES  = 4 * PIPE_LATENCY;
    localparam int REPORT_LIMIT   = 10;

    // Value kinds that the package does not name.
    localparam logic [1:0] KIND_FLOAT  = 2'd1;
    localparam logic [1:0] KIND_DOUBLE = 2'd2;

    localparam logic signed [31:0] SCALE_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] SCALE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SCALE_MIN = 32'sh8000_0000;
    localparam logic [63:0]        ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        PATTERN   = 64'h0123_4567_89AB_CDEF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cse_in_if  in_ch ();
    cse_out_if out_ch ();

    can_signal_extract_scale dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoded signals still owed by the block, oldest first.
    t_result expected_results[$];
    int      error_count = 0;
    int      sink_wait   = 0;
    bit      send_idle   = 1'b1;
    bit      recv_idle   = 1'b1;

    // Number of idle cycles before the next item on one side. At least a third
    // of the draws are zero so that back-to-back runs still occur with idling on.
    function automatic int pick_wait(input bit enabled);
        if (!enabled)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // Predicts the one result that a request produces. The length check uses
    // the last byte touched by the signal in either byte order, the unknown
    // kind only matters once the length is fine, and integer signals go
    // through an exact wide multiply before the offset add and the clip.
    function automatic t_result decode_signal(input t_item req);
        t_result      res;
        int unsigned  lim, so, endb, len, p, n;
        logic [63:0]  raw, rmag, omag;
        logic [32:0]  smag;
        logic [127:0] prod;
        logic [64:0]  sum, clip;
        logic         rneg, sneg, oneg, pneg, neg;

        res  = '0;
        raw  = '0;
        len  = 32'(req.bit_length);
        lim  = (32'(req.byte_count) < CAN_BYTES) ? 32'(req.byte_count) : CAN_BYTES;
        so   = 32'(req.start_bit[2:0]);
        if (len > 32'(MAX_BIT_LENGTH)) begin
            res.status = ST_LENGTH;
        end else if (len != 0) begin
            if (req.motorola_order)
                endb = 32'(req.start_bit) / BITS_PER_BYTE + (len + 6 - so) / BITS_PER_BYTE;
            else
                endb = (32'(req.start_bit) + len - 1) / BITS_PER_BYTE;
            if (endb >= lim)
                res.status = ST_LENGTH;
        end
        if (res.status == ST_OK && req.value_kind == KIND_UNKNOWN)
            res.status = ST_KIND;
        if (res.status != ST_OK)
            return res;

        if (req.motorola_order) begin
            // Walk down inside a byte, then jump to bit 7 of the next byte.
            p = 32'(req.start_bit);
            for (n = 0; n < len; n++) begin
                raw = {raw[62:0], (p < 64) ? req.payload[p[5:0]] : 1'b0};
                p   = (p % BITS_PER_BYTE == 0) ? p + 15 : p - 1;
            end
        end else begin
            raw = req.payload >> req.start_bit;
            if (len < 64)
                raw = raw & ((64'd1 << len) - 64'd1);
        end
        res.raw_bits = raw;

        if (req.value_kind == KIND_INT) begin
            if (req.is_signed && len > 0 && len < 64 && raw[len - 1])
                raw = raw | ~((64'd1 << len) - 64'd1);
            res.raw_bits = raw;
            rneg = req.is_signed && raw[63];
            rmag = rneg ? (64'd0 - raw) : raw;
            sneg = req.scale_factor[31];
            smag = sneg ? (33'h1_0000_0000 - {1'b0, $unsigned(req.scale_factor)})
                        : {1'b0, $unsigned(req.scale_factor)};
            oneg = req.offset_value[63];
            omag = oneg ? (64'd0 - $unsigned(req.offset_value)) : $unsigned(req.offset_value);
            pneg = rneg ^ sneg;
            prod = ({64'd0, rmag} * {95'd0, smag}) << PROD_SHIFT;

            if (prod[127:64] != 0) begin
                // The product alone is beyond any offset's reach.
                res.saturated      = 1'b1;
                res.physical_value = pneg ? PHYS_MIN : PHYS_MAX;
            end else begin
                if (pneg == oneg) begin
                    sum = {1'b0, prod[63:0]} + {1'b0, omag};
                    neg = pneg;
                end else if (prod[63:0] >= omag) begin
                    sum = {1'b0, prod[63:0] - omag};
                    neg = pneg;
                end else begin
                    sum = {1'b0, omag - prod[63:0]};
                    neg = oneg;
                end
                clip = neg ? (65'd1 << 63) : ((65'd1 << 63) - 65'd1);
                if (sum > clip) begin
                    sum           = clip;
                    res.saturated = 1'b1;
                end
                res.physical_value = neg ? (64'd0 - sum[63:0]) : sum[63:0];
            end
        end
        return res;
    endfunction

    function automatic t_item make_request(input logic [63:0] payload, input int cnt,
                                           input int sb, input int len, input bit mot,
                                           input bit sgn, input logic [1:0] kind,
                                           input logic signed [31:0] scale,
                                           input logic signed [63:0] offset);
        t_item req;
        req.payload        = payload;
        req.byte_count     = 4'(cnt);
        req.start_bit      = 6'(sb);
        req.bit_length     = 7'(len);
        req.motorola_order = mot;
        req.is_signed      = sgn;
        req.value_kind     = kind;
        req.scale_factor   = scale;
        req.offset_value   = offset;
        return req;
    endfunction

    // Random request. A well-formed one places the signal inside the valid
    // bytes for its byte order so that extraction and scaling are reached;
    // the rest draws every field over its whole width.
    function automatic t_item random_request(input bit well_formed);
        t_item       req;
        int unsigned lim, len, so, nbytes;
        logic [31:0] word;

        req.payload        = {$urandom, $urandom};
        req.motorola_order = 1'($urandom_range(0, 1));
        req.is_signed      = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       req.scale_factor = $urandom;
            1:       req.scale_factor = SCALE_ONE;
            default: req.scale_factor = $urandom_range(0, 32'h3_FFFF) - 32'h1_FFFF;
        endcase
        word = $urandom;
        case ($urandom_range(0, 5))
            0:       req.offset_value = {$urandom, $urandom};
            1:       req.offset_value = PHYS_MAX;
            2:       req.offset_value = PHYS_MIN;
            default: req.offset_value = {{32{word[31]}}, word};
        endcase
        case ($urandom_range(0, 9))
            7:       req.value_kind = KIND_FLOAT;
            8:       req.value_kind = KIND_DOUBLE;
            9:       req.value_kind = KIND_UNKNOWN;
            default: req.value_kind = KIND_INT;
        endcase

        if (!well_formed) begin
            req.byte_count = 4'($urandom_range(0, 15));
            req.start_bit  = 6'($urandom_range(0, 63));
            req.bit_length = 7'($urandom_range(0, 127));
            req.value_kind = 2'($urandom_range(0, 3));
            return req;
        end

        lim = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CAN_BYTES) : CAN_BYTES;
        req.byte_count = 4'(lim);
        if ($urandom_range(0, 2) == 0)
            len = $urandom_range(1, 8 * lim);
        else
            len = $urandom_range(1, (8 * lim < 16) ? 8 * lim : 16);
        req.bit_length = 7'(len);
        if (req.motorola_order) begin
            // Bytes spanned depend on where the MSB sits in its byte; bit 7
            // of a byte always leaves room for any length that fits at all.
            so     = $urandom_range(0, 7);
            nbytes = (len + 6 - so) / BITS_PER_BYTE + 1;
            if (nbytes > lim) begin
                so     = 7;
                nbytes = (len - 1) / BITS_PER_BYTE + 1;
            end
            req.start_bit = 6'($urandom_range(0, lim - nbytes) * BITS_PER_BYTE + so);
        end else begin
            req.start_bit = 6'($urandom_range(0, 8 * lim - len));
        end
        return req;
    endfunction

    // Presents one request after a random gap and returns just after the
    // clock edge at which it was taken, with its prediction queued.
    task automatic send_item(input t_item req);
        int gap;
        gap = pick_wait(send_idle);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid          <= 1'b1;
        in_ch.payload        <= req.payload;
        in_ch.byte_count     <= req.byte_count;
        in_ch.start_bit      <= req.start_bit;
        in_ch.bit_length     <= req.bit_length;
        in_ch.motorola_order <= req.motorola_order;
        in_ch.is_signed      <= req.is_signed;
        in_ch.value_kind     <= req.value_kind;
        in_ch.scale_factor   <= req.scale_factor;
        in_ch.offset_value   <= req.offset_value;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        expected_results.push_back(decode_signal(req));
    endtask

    // Stops sending and waits until every queued result has come back.
    task automatic wait_until_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Field extremes, both byte orders, every value kind, the length and
    // kind faults with their precedence, empty and overlong signals, byte
    // counts above eight, and the saturation corners of the scaling.
    task automatic test_directed_cases();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_item(make_request(ALL_ONES, 8, 0, 64, 0, 0, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(ALL_ONES, 8, 0, 64, 0, 1, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(PATTERN, 8, 7, 64, 1, 1, KIND_INT, SCALE_MIN, PHYS_MAX));
        send_item(make_request(PATTERN, 8, 63, 1, 1, 0, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(ALL_ONES, 8, 63, 1, 0, 1, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(ALL_ONES, 8, 63, 2, 0, 0, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(ALL_ONES, 8, 0, 0, 0, 0, KIND_INT, SCALE_MAX, PHYS_MIN));
        send_item(make_request(ALL_ONES, 0, 0, 0, 1, 1, KIND_UNKNOWN, SCALE_ONE, 0));
        send_item(make_request(ALL_ONES, 8, 0, 65, 0, 0, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(ALL_ONES, 8, 0, 127, 1, 1, KIND_UNKNOWN, SCALE_ONE, 0));
        send_item(make_request(ALL_ONES, 0, 0, 1, 0, 0, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(PATTERN, 15, 56, 8, 0, 1, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(PATTERN, 4, 24, 8, 0, 0, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(PATTERN, 4, 25, 8, 0, 0, KIND_INT, SCALE_ONE, 0));
        // Motorola signals that cross a byte boundary.
        send_item(make_request(PATTERN, 2, 4, 12, 1, 1, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(PATTERN, 1, 4, 12, 1, 1, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(PATTERN, 2, 0, 2, 1, 0, KIND_INT, SCALE_ONE, 0));
        // Float and double keep their bits without sign extension.
        send_item(make_request(ALL_ONES, 8, 0, 32, 0, 1, KIND_FLOAT, SCALE_ONE, PHYS_MAX));
        send_item(make_request(PATTERN, 8, 0, 64, 0, 1, KIND_DOUBLE, SCALE_MIN, 0));
        // Lands exactly on the most negative value without clipping.
        send_item(make_request(64'h8000_0000, 8, 0, 32, 0, 1, KIND_INT, SCALE_ONE, 0));
        send_item(make_request(64'h1, 8, 0, 1, 0, 0, KIND_INT, SCALE_MIN, PHYS_MAX));
        send_item(make_request(64'h8000_0000_0000_0000, 8, 0, 64, 0, 1, KIND_INT,
                               SCALE_MIN, 0));
        send_item(make_request(64'h7FFF, 8, 0, 16, 0, 0, KIND_INT, SCALE_ONE, PHYS_MAX));
        send_item(make_request(64'hFFFF, 8, 0, 16, 0, 1, KIND_INT, SCALE_ONE, PHYS_MIN));
        send_item(make_request(64'h1, 8, 0, 1, 0, 0, KIND_INT, SCALE_MAX, 0));
    endtask

    // Full rate first, then a stalling receiver against a sender that never
    // pauses, so the pipeline fills from the back and input ready drops.
    task automatic test_streaming();
        int n;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (n = 0; n < 200; n++)
            send_item(random_request($urandom_range(0, 99) < 85));
        recv_idle = 1'b1;
        for (n = 0; n < 200; n++)
            send_item(random_request($urandom_range(0, 99) < 85));
    endtask

    // Short bursts, each followed by a pause until every result is back.
    task automatic test_pause_until_drained();
        int burst, n;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        for (burst = 0; burst < 4; burst++) begin
            for (n = 0; n < 25; n++)
                send_item(random_request($urandom_range(0, 99) < 85));
            wait_until_drained();
        end
    endtask

    // Bulk of the random items with both sides idling at random.
    task automatic test_random_idling();
        int n;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        for (n = 0; n < 1000; n++)
            send_item(random_request($urandom_range(0, 99) < 85));
    endtask

    // Result sink: after each taken result it holds ready low for a drawn
    // number of cycles, and keeps it high otherwise.
    always @(negedge i_clk) begin
        if (sink_wait > 0) begin
            out_ch.ready <= 1'b0;
            sink_wait--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compares every taken result with the oldest prediction.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status         = out_ch.status;
            got.raw_bits       = out_ch.raw_bits;
            got.physical_value = out_ch.physical_value;
            got.saturated      = out_ch.saturated;
            sink_wait          = pick_wait(recv_idle);
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("Unexpected result: status=%0d raw=%h phys=%h sat=%0b",
                             got.status, got.raw_bits, got.physical_value, got.saturated);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.raw_bits !== want.raw_bits ||
                    got.physical_value !== want.physical_value ||
                    got.saturated !== want.saturated) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"Mismatch: expected status=%0d raw=%h phys=%h sat=%0b, ",
                                  "got status=%0d raw=%h phys=%h sat=%0b"},
                                 want.status, want.raw_bits, want.physical_value,
                                 want.saturated, got.status, got.raw_bits,
                                 got.physical_value, got.saturated);
                end
            end
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.payload        = '0;
        in_ch.byte_count     = '0;
        in_ch.start_bit      = '0;
        in_ch.bit_length     = '0;
        in_ch.motorola_order = 1'b0;
        in_ch.is_signed      = 1'b0;
        in_ch.value_kind     = KIND_INT;
        in_ch.scale_factor   = '0;
        in_ch.offset_value   = '0;
        out_ch.ready         = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_streaming();
        test_pause_until_drained();
        test_random_idling();

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Far beyond the slowest correct run, with every gap and stall at its longest.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
